@@ rtl/core/prbs_ber_pkg.sv @@
// shared types, constants and functions of the prbs generator and bit error checker
package prbs_ber_pkg;

  // widths
  localparam int COUNT_WIDTH = 48;
  localparam int LOSS_WIDTH  = 32;
  localparam int LFSR_WIDTH  = 23;
  localparam int CFG_WIDTH   = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_BITS    = 8 + 4 + 3 * COUNT_WIDTH + LOSS_WIDTH + 1;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = {COUNT_WIDTH{1'b1}};
  localparam logic [LOSS_WIDTH-1:0]  LOSS_MAX = {LOSS_WIDTH{1'b1}};
  localparam logic [LFSR_WIDTH-1:0]  LFSR_SEED = LFSR_WIDTH'(1);

  // fixed transmit bytes
  localparam logic [7:0] BYTE_AA = 8'hAA;
  localparam logic [7:0] BYTE_55 = 8'h55;
  localparam logic [7:0] BYTE_FF = 8'hFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORDER   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN = 1'b1;

  // function codes of an input beat
  typedef enum logic [1:0] {
    FUNC_RESTART = 2'd0,
    FUNC_TRANSMIT = 2'd1,
    FUNC_CHECK = 2'd2,
    FUNC_FAIL = 2'd3
  } func_t;

  // lfsr order codes
  typedef enum logic [2:0] {
    ORDER_7  = 3'd0,
    ORDER_9  = 3'd1,
    ORDER_15 = 3'd2,
    ORDER_23 = 3'd3,
    ORDER_11 = 3'd4
  } order_t;

  // transmit pattern codes
  typedef enum logic [2:0] {
    PAT_COUNTER = 3'd0,
    PAT_PRBS    = 3'd1,
    PAT_WALK    = 3'd2,
    PAT_AA      = 3'd3,
    PAT_55      = 3'd4,
    PAT_FF      = 3'd5
  } pattern_t;

  localparam logic [CFG_WIDTH-1:0] ORDER_RESET   = ORDER_15;
  localparam logic [CFG_WIDTH-1:0] PATTERN_RESET = PAT_PRBS;

  typedef struct packed {
    logic [LFSR_WIDTH-1:0] state;
    logic [7:0]            data;
  } prbs_res_t;

  // eight lfsr steps, msb first; the feedback bit is also the output bit
  function automatic prbs_res_t prbs_byte(input logic [LFSR_WIDTH-1:0] seed,
                                          input logic [CFG_WIDTH-1:0] sel);
    logic [LFSR_WIDTH-1:0] s;
    logic [7:0]            b;
    logic [4:0]            hi;
    logic [4:0]            lo;
    logic                  fb;
    prbs_res_t             res;
    s = seed;
    b = '0;
    unique case (sel)
      ORDER_7:  begin hi = 5'd6;  lo = 5'd5;  end
      ORDER_9:  begin hi = 5'd8;  lo = 5'd4;  end
      ORDER_15: begin hi = 5'd14; lo = 5'd13; end
      ORDER_23: begin hi = 5'd22; lo = 5'd17; end
      default:  begin hi = 5'd10; lo = 5'd6;  end
    endcase
    for (int k = 0; k < 8; k++) begin
      fb = s[hi] ^ s[lo];
      s = {s[LFSR_WIDTH-2:0], fb};
      b = {b[6:0], fb};
    end
    res.state = s;
    res.data = b;
    return res;
  endfunction

  // count of set bits in a byte
  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] c;
    c = '0;
    for (int k = 0; k < 8; k++) begin
      c = c + 4'(v[k]);
    end
    return c;
  endfunction

  // saturating add of a small increment
  function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] total,
                                                     input logic [3:0] inc);
    logic [COUNT_WIDTH:0] sum;
    sum = {1'b0, total} + (COUNT_WIDTH + 1)'(inc);
    return sum[COUNT_WIDTH] ? CNT_MAX : sum[COUNT_WIDTH-1:0];
  endfunction

endpackage

@@ rtl/core/prbs_pattern_generator_ber_checker_unit.sv @@
// top level of the prbs pattern generator and bit error rate checker
//
// Link test block. Each input beat carries a function in s_tuser: restart (reseed
// both lfsrs to 1 and clear all counters), transmit one byte (pattern chosen by
// the pattern register, prbs order by the order register), check one received
// byte against the checker's own prbs byte, or record a receive failure. Every
// input beat yields exactly one result beat with the transmit byte, the bit
// errors of this byte and the running saturating totals. One beat is accepted
// per clock while the skid stage is empty: the eight lfsr steps and the popcount
// are a single combinational pass from the state registers into the result
// register, and a one-entry skid stage behind the result register lets the input
// side keep going for one beat while the output side stalls. A beat parked in
// the skid stage waits until the beat ahead of it leaves. Configuration is
// written through cfg_we/cfg_index/cfg_data while idle; the user must keep to
// this, as the block does not enforce it.
module prbs_pattern_generator_ber_checker_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration write port
  input  logic                                   cfg_we,
  input  logic [prbs_ber_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [prbs_ber_pkg::CFG_WIDTH-1:0]     cfg_data,
  // input stream
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // rx_byte[7:0], packet_seq[23:8], byte_pos[31:24]
  input  logic [prbs_ber_pkg::IN_TDATA_W-1:0]    s_tdata,
  // func[1:0]
  input  logic [prbs_ber_pkg::IN_TUSER_W-1:0]    s_tuser,
  // result stream
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // tx_byte[7:0], byte_bit_errors[11:8], total_bit_errors[59:12],
  // bits_received[107:60], bits_sent[155:108], sync_loss_count[187:156],
  // link_synced[188], zero fill above
  output logic [prbs_ber_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import prbs_ber_pkg::*;

  // configuration registers
  logic [CFG_WIDTH-1:0] order_sel;
  logic [CFG_WIDTH-1:0] pattern_mode;

  // block state
  logic [LFSR_WIDTH-1:0]  tx_lfsr;
  logic [LFSR_WIDTH-1:0]  rx_lfsr;
  logic [COUNT_WIDTH-1:0] error_total;
  logic [COUNT_WIDTH-1:0] received_total;
  logic [COUNT_WIDTH-1:0] sent_total;
  logic [LOSS_WIDTH-1:0]  loss_total;
  logic                   synced;

  logic [LFSR_WIDTH-1:0]  tx_lfsr_next;
  logic [LFSR_WIDTH-1:0]  rx_lfsr_next;
  logic [COUNT_WIDTH-1:0] error_total_next;
  logic [COUNT_WIDTH-1:0] received_total_next;
  logic [COUNT_WIDTH-1:0] sent_total_next;
  logic [LOSS_WIDTH-1:0]  loss_total_next;
  logic                   synced_next;

  // result register and skid stage
  logic                   out_valid;
  logic [OUT_TDATA_W-1:0] out_data;
  logic                   skid_valid;
  logic [OUT_TDATA_W-1:0] skid_data;

  // input fields
  func_t      func;
  logic [7:0] rx_byte;
  logic [15:0] packet_seq;
  logic [7:0] byte_pos;

  logic [7:0]             tx_byte;
  logic [3:0]             byte_errs;
  logic [OUT_TDATA_W-1:0] result;
  prbs_res_t              tx_prbs;
  prbs_res_t              rx_prbs;

  logic push;
  logic pop;

  assign func       = func_t'(s_tuser);
  assign rx_byte    = s_tdata[7:0];
  assign packet_seq = s_tdata[23:8];
  assign byte_pos   = s_tdata[31:24];

  assign s_tready = !skid_valid;
  assign push     = s_tvalid && s_tready;
  assign pop      = out_valid && m_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  assign tx_prbs = prbs_byte(tx_lfsr, order_sel);
  assign rx_prbs = prbs_byte(rx_lfsr, order_sel);

  // next state and result of one beat
  always_comb begin
    tx_byte             = '0;
    byte_errs           = '0;
    tx_lfsr_next        = tx_lfsr;
    rx_lfsr_next        = rx_lfsr;
    error_total_next    = error_total;
    received_total_next = received_total;
    sent_total_next     = sent_total;
    loss_total_next     = loss_total;
    synced_next         = synced;
    unique case (func)
      FUNC_RESTART: begin
        tx_lfsr_next        = LFSR_SEED;
        rx_lfsr_next        = LFSR_SEED;
        error_total_next    = '0;
        received_total_next = '0;
        sent_total_next     = '0;
        loss_total_next     = '0;
        synced_next         = 1'b0;
      end
      FUNC_TRANSMIT: begin
        unique case (pattern_mode)
          PAT_COUNTER: tx_byte = packet_seq[7:0] + byte_pos;
          PAT_PRBS: begin
            tx_byte      = tx_prbs.data;
            tx_lfsr_next = tx_prbs.state;
          end
          PAT_WALK: tx_byte = 8'd1 << byte_pos[2:0];
          PAT_AA:   tx_byte = BYTE_AA;
          PAT_55:   tx_byte = BYTE_55;
          default:  tx_byte = BYTE_FF;
        endcase
        sent_total_next = sat_add(sent_total, 4'd8);
      end
      FUNC_CHECK: begin
        byte_errs           = popcount8(rx_byte ^ rx_prbs.data);
        rx_lfsr_next        = rx_prbs.state;
        received_total_next = sat_add(received_total, 4'd8);
        error_total_next    = sat_add(error_total, byte_errs);
        synced_next         = 1'b1;
      end
      default: begin
        if (loss_total != LOSS_MAX) begin
          loss_total_next = loss_total + LOSS_WIDTH'(1);
        end
        synced_next = 1'b0;
      end
    endcase
    result = OUT_TDATA_W'({synced_next, loss_total_next, sent_total_next,
                           received_total_next, error_total_next, byte_errs, tx_byte});
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      order_sel    <= ORDER_RESET;
      pattern_mode <= PATTERN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORDER:   order_sel    <= cfg_data;
        default:     pattern_mode <= cfg_data;
      endcase
    end
  end

  // state update on an accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_lfsr        <= LFSR_SEED;
      rx_lfsr        <= LFSR_SEED;
      error_total    <= '0;
      received_total <= '0;
      sent_total     <= '0;
      loss_total     <= '0;
      synced         <= 1'b0;
    end else if (push) begin
      tx_lfsr        <= tx_lfsr_next;
      rx_lfsr        <= rx_lfsr_next;
      error_total    <= error_total_next;
      received_total <= received_total_next;
      sent_total     <= sent_total_next;
      loss_total     <= loss_total_next;
      synced         <= synced_next;
    end
  end

  // result register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_data <= result;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_data  <= result;
        skid_valid <= 1'b1;
      end else begin
        out_data  <= result;
        out_valid <= 1'b1;
      end
    end
  end

endmodule

@@ tb/sv/prbs_pattern_generator_ber_checker_unit_test.sv @@
// self-checking testbench of the prbs pattern generator and bit error rate checker
`timescale 1ns / 1ps

module prbs_pattern_generator_ber_checker_unit_test;
  import prbs_ber_pkg::*;

  // one input beat and one predicted result
  typedef struct {
    func_t      func;
    logic [7:0] rx_byte;
    logic [15:0] packet_seq;
    logic [7:0] byte_pos;
  } link_beat_t;

  typedef struct {
    logic [7:0]             tx_byte;
    logic [3:0]             byte_errs;
    logic [COUNT_WIDTH-1:0] err_total;
    logic [COUNT_WIDTH-1:0] rx_bits;
    logic [COUNT_WIDTH-1:0] tx_bits;
    logic [LOSS_WIDTH-1:0]  losses;
    logic                   synced;
  } link_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic [IN_TUSER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  prbs_pattern_generator_ber_checker_unit DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  link_beat_t   beats_to_send[$];
  link_result_t link_results_due[$];

  // predictor state and its copy of the registers
  logic [LFSR_WIDTH-1:0]  gen_lfsr;
  logic [LFSR_WIDTH-1:0]  chk_lfsr;
  logic [COUNT_WIDTH-1:0] err_count;
  logic [COUNT_WIDTH-1:0] rx_count;
  logic [COUNT_WIDTH-1:0] tx_count;
  logic [LOSS_WIDTH-1:0]  loss_count;
  logic                   sync_flag;
  logic [CFG_WIDTH-1:0]   order_reg;
  logic [CFG_WIDTH-1:0]   pattern_reg;

  // stimulus side shadow of the checker lfsr, used to build matching rx bytes
  logic [LFSR_WIDTH-1:0] rx_shadow = LFSR_WIDTH'(1);
  logic [CFG_WIDTH-1:0]  stim_order = ORDER_15;

  logic beat_taken = 1'b0;
  bit   steady = 1'b0;
  int   mismatches = 0;
  int   results_seen = 0;
  int   settings_used = 0;
  int   func_hits[4] = '{0, 0, 0, 0};

  // eight lfsr steps msb first; returns {next state, byte}
  function automatic logic [LFSR_WIDTH+7:0] lfsr_byte(input logic [LFSR_WIDTH-1:0] st,
                                                      input logic [CFG_WIDTH-1:0] sel);
    int         hi;
    int         lo;
    logic       fb;
    logic [7:0] out;
    out = '0;
    case (sel)
      ORDER_7:  begin hi = 6;  lo = 5;  end
      ORDER_9:  begin hi = 8;  lo = 4;  end
      ORDER_15: begin hi = 14; lo = 13; end
      ORDER_23: begin hi = 22; lo = 17; end
      default:  begin hi = 10; lo = 6;  end
    endcase
    for (int k = 0; k < 8; k++) begin
      fb = st[hi] ^ st[lo];
      st = {st[LFSR_WIDTH-2:0], fb};
      out = {out[6:0], fb};
    end
    return {st, out};
  endfunction

  function automatic logic [3:0] ones_in(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int k = 0; k < 8; k++) n = n + {3'b0, v[k]};
    return n;
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] add_clamped(input logic [COUNT_WIDTH-1:0] acc,
                                                         input logic [3:0] inc);
    if (acc > CNT_MAX - COUNT_WIDTH'(inc)) return CNT_MAX;
    return acc + COUNT_WIDTH'(inc);
  endfunction

  // apply one beat to the predictor and queue the result it must produce
  task automatic predict_link_result(input link_beat_t b);
    link_result_t r;
    logic [LFSR_WIDTH+7:0] step;
    r.tx_byte = '0;
    r.byte_errs = '0;
    case (b.func)
      FUNC_RESTART: begin
        gen_lfsr = LFSR_WIDTH'(1);
        chk_lfsr = LFSR_WIDTH'(1);
        err_count = '0;
        rx_count = '0;
        tx_count = '0;
        loss_count = '0;
        sync_flag = 1'b0;
      end
      FUNC_TRANSMIT: begin
        case (pattern_reg)
          PAT_COUNTER: r.tx_byte = b.packet_seq[7:0] + b.byte_pos;
          PAT_PRBS: begin
            step = lfsr_byte(gen_lfsr, order_reg);
            gen_lfsr = step[LFSR_WIDTH+7:8];
            r.tx_byte = step[7:0];
          end
          PAT_WALK: r.tx_byte = 8'h01 << b.byte_pos[2:0];
          PAT_AA:   r.tx_byte = 8'hAA;
          PAT_55:   r.tx_byte = 8'h55;
          default:  r.tx_byte = 8'hFF;
        endcase
        tx_count = add_clamped(tx_count, 4'd8);
      end
      FUNC_CHECK: begin
        step = lfsr_byte(chk_lfsr, order_reg);
        chk_lfsr = step[LFSR_WIDTH+7:8];
        r.byte_errs = ones_in(b.rx_byte ^ step[7:0]);
        rx_count = add_clamped(rx_count, 4'd8);
        err_count = add_clamped(err_count, r.byte_errs);
        sync_flag = 1'b1;
      end
      default: begin
        if (loss_count != LOSS_MAX) loss_count = loss_count + LOSS_WIDTH'(1);
        sync_flag = 1'b0;
      end
    endcase
    r.err_total = err_count;
    r.rx_bits = rx_count;
    r.tx_bits = tx_count;
    r.losses = loss_count;
    r.synced = sync_flag;
    link_results_due.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t ns: %s got %0h want %0h", $time, what, got, want);
    mismatches++;
  endtask

  // queue one beat; a check byte is the shadow prbs byte xor flip unless raw
  task automatic queue_beat(input func_t f, input bit raw, input logic [7:0] rx,
                            input logic [15:0] seq, input logic [7:0] pos);
    link_beat_t b;
    logic [LFSR_WIDTH+7:0] step;
    b.func = f;
    b.rx_byte = rx;
    b.packet_seq = seq;
    b.byte_pos = pos;
    if (f == FUNC_RESTART) rx_shadow = LFSR_WIDTH'(1);
    if (f == FUNC_CHECK) begin
      step = lfsr_byte(rx_shadow, stim_order);
      rx_shadow = step[LFSR_WIDTH+7:8];
      if (!raw) b.rx_byte = step[7:0] ^ rx;
    end
    beats_to_send.push_back(b);
  endtask

  // wait until every beat went in and every result came back
  task automatic drain();
    while (beats_to_send.size() != 0 || s_tvalid || link_results_due.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // register writes happen only while the block is idle
  task automatic write_config(input logic [CFG_WIDTH-1:0] ord,
                              input logic [CFG_WIDTH-1:0] pat);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_ORDER;
    cfg_data <= ord;
    @(negedge clk);
    cfg_index <= REG_PATTERN;
    cfg_data <= pat;
    @(negedge clk);
    cfg_we <= 1'b0;
    stim_order = ord;
    settings_used++;
  endtask

  task automatic queue_random_beat();
    int         roll;
    int         flavor;
    logic [7:0] flip;
    roll = $urandom_range(99);
    flavor = $urandom_range(99);
    flip = 8'h00;
    if (flavor >= 70 && flavor < 90) flip = 8'h01 << $urandom_range(7);
    if (roll < 4)
      queue_beat(FUNC_RESTART, 1'b1, 8'($urandom), 16'($urandom), 8'($urandom));
    else if (roll < 44)
      queue_beat(FUNC_TRANSMIT, 1'b1, 8'($urandom), 16'($urandom), 8'($urandom));
    else if (roll < 90)
      queue_beat(FUNC_CHECK, flavor >= 90, flavor >= 90 ? 8'($urandom) : flip,
                 16'($urandom), 8'($urandom));
    else
      queue_beat(FUNC_FAIL, 1'b1, 8'($urandom), 16'($urandom), 8'($urandom));
  endtask

  // input side: register capture, accepted beats into the predictor
  always @(posedge clk) begin
    if (rst) begin
      gen_lfsr = LFSR_WIDTH'(1);
      chk_lfsr = LFSR_WIDTH'(1);
      err_count = '0;
      rx_count = '0;
      tx_count = '0;
      loss_count = '0;
      sync_flag = 1'b0;
      order_reg = ORDER_RESET;
      pattern_reg = PATTERN_RESET;
      beat_taken = 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ORDER) order_reg = cfg_data;
        else pattern_reg = cfg_data;
      end
      beat_taken = s_tvalid && s_tready;
      if (beat_taken) begin
        func_hits[s_tuser]++;
        predict_link_result('{func: func_t'(s_tuser), rx_byte: s_tdata[7:0],
                              packet_seq: s_tdata[23:8], byte_pos: s_tdata[31:24]});
      end
    end
  end

  // driver: next beat at the falling edge, random gaps unless steady
  always @(negedge clk) begin : drive_beats
    link_beat_t nxt;
    bit         gap;
    gap = !steady && ($urandom_range(99) < 29);
    if (!rst && !(s_tvalid && !beat_taken)) begin
      if (beats_to_send.size() != 0 && !gap) begin
        nxt = beats_to_send.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {nxt.byte_pos, nxt.packet_seq, nxt.rx_byte};
        s_tuser <= nxt.func;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= steady || ($urandom_range(99) >= 29);
  end

  // monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin : check_results
    link_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (link_results_due.size() == 0) begin
        report_mismatch("result beat with nothing due", 64'(m_tdata[59:0]), 64'd0);
      end else begin
        want = link_results_due.pop_front();
        if (m_tdata[7:0] !== want.tx_byte)
          report_mismatch("tx_byte", 64'(m_tdata[7:0]), 64'(want.tx_byte));
        if (m_tdata[11:8] !== want.byte_errs)
          report_mismatch("byte_bit_errors", 64'(m_tdata[11:8]), 64'(want.byte_errs));
        if (m_tdata[59:12] !== want.err_total)
          report_mismatch("total_bit_errors", 64'(m_tdata[59:12]), 64'(want.err_total));
        if (m_tdata[107:60] !== want.rx_bits)
          report_mismatch("bits_received", 64'(m_tdata[107:60]), 64'(want.rx_bits));
        if (m_tdata[155:108] !== want.tx_bits)
          report_mismatch("bits_sent", 64'(m_tdata[155:108]), 64'(want.tx_bits));
        if (m_tdata[187:156] !== want.losses)
          report_mismatch("sync_loss_count", 64'(m_tdata[187:156]), 64'(want.losses));
        if (m_tdata[188] !== want.synced)
          report_mismatch("link_synced", 64'(m_tdata[188]), 64'(want.synced));
      end
    end
  end

  // stimulus: directed beats, then random phases under changing settings
  initial begin
    logic [CFG_WIDTH-1:0] ord;
    logic [CFG_WIDTH-1:0] pat;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: prbs15 transmit and check, failures, restart
    queue_beat(FUNC_TRANSMIT, 1'b1, 8'h00, 16'h0000, 8'h00);
    queue_beat(FUNC_TRANSMIT, 1'b1, 8'hFF, 16'hFFFF, 8'hFF);
    queue_beat(FUNC_CHECK, 1'b0, 8'h00, 16'h0000, 8'h00);
    queue_beat(FUNC_CHECK, 1'b1, 8'h00, 16'hFFFF, 8'hFF);
    queue_beat(FUNC_CHECK, 1'b1, 8'hFF, 16'h0000, 8'h00);
    queue_beat(FUNC_CHECK, 1'b0, 8'h01, 16'h0000, 8'h00);
    queue_beat(FUNC_FAIL, 1'b1, 8'hFF, 16'hFFFF, 8'hFF);
    queue_beat(FUNC_FAIL, 1'b1, 8'h00, 16'h0000, 8'h00);
    queue_beat(FUNC_CHECK, 1'b0, 8'h00, 16'h0000, 8'h00);
    queue_beat(FUNC_RESTART, 1'b1, 8'hFF, 16'hFFFF, 8'hFF);
    queue_beat(FUNC_TRANSMIT, 1'b1, 8'h00, 16'h0000, 8'h00);
    queue_beat(FUNC_CHECK, 1'b0, 8'h00, 16'h0000, 8'h00);
    queue_beat(FUNC_CHECK, 1'b0, 8'h80, 16'h0000, 8'h00);
    drain();

    // counter pattern wrap at the lowest order
    write_config(ORDER_7, PAT_COUNTER);
    queue_beat(FUNC_TRANSMIT, 1'b1, 8'h00, 16'hFFFF, 8'h01);
    queue_beat(FUNC_TRANSMIT, 1'b1, 8'h00, 16'h0000, 8'h00);
    drain();

    // remaining patterns, unused codes too, each with the order code set to its pattern code
    for (int p = 2; p < 8; p++) begin
      write_config(CFG_WIDTH'(p), CFG_WIDTH'(p));
      queue_beat(FUNC_TRANSMIT, 1'b1, 8'h00, 16'(p), 8'(p * 37));
      queue_beat(FUNC_CHECK, 1'b0, 8'h00, 16'h0000, 8'h00);
      drain();
    end

    // random phases; the first eight walk every order code
    for (int ph = 0; ph < 20; ph++) begin
      ord = (ph < 8) ? CFG_WIDTH'(ph) : CFG_WIDTH'($urandom_range(7));
      pat = (ph % 2 == 0) ? CFG_WIDTH'(PAT_PRBS) : CFG_WIDTH'($urandom_range(7));
      write_config(ord, pat);
      steady = (ph == 10);
      for (int i = 0; i < 55; i++) queue_random_beat();
      drain();
      steady = 1'b0;
    end

    repeat (5) @(posedge clk);
    if (link_results_due.size() != 0)
      report_mismatch("results still due at end", 64'(link_results_due.size()), 64'd0);
    $display("ran %0d beats: %0d restart, %0d transmit, %0d check, %0d failure",
             func_hits[0] + func_hits[1] + func_hits[2] + func_hits[3],
             func_hits[0], func_hits[1], func_hits[2], func_hits[3]);
    $display("checked %0d result beats over %0d register settings, %0d mismatches",
             results_seen, settings_used, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hang guard
  initial begin
    #2000000;
    $display("timeout with %0d results still due", link_results_due.size());
    $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/prbs_ber_pkg.sv
rtl/core/prbs_pattern_generator_ber_checker_unit.sv
tb/sv/prbs_pattern_generator_ber_checker_unit_test.sv
